// ===== rtl/gmb_pkg.sv =====
`default_nettype none

package gmb_pkg;

   // grid and store sizes
   localparam int CELL_W    = 12;
   localparam int MAX_CELLS = 1 << CELL_W;
   localparam int CNT_W     = CELL_W + 1;
   localparam int DIM_W     = 7;
   localparam int CRD_W     = 6;
   localparam int STK_W     = CELL_W + 2 * CRD_W;
   localparam int GRID_W    = 5;

   // dimension limits and reset values
   localparam logic [DIM_W-1:0] DIM_MIN   = 7'd2;
   localparam logic [DIM_W-1:0] DIM_MAX   = 7'd64;
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd16;
   localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd256;

   localparam logic [3:0] WALLS_ALL  = 4'hf;
   localparam logic [3:0] WALLS_NONE = 4'h0;
   localparam logic [3:0] WALL_ONE   = 4'h1;

   // request modes
   localparam logic [1:0] MODE_RESTART = 2'd0;
   localparam logic [1:0] MODE_STEP    = 2'd1;
   localparam logic [1:0] MODE_READ    = 2'd2;

   // directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   // result events
   localparam logic [2:0] EV_STARTED  = 3'd0;
   localparam logic [2:0] EV_BLOCKED  = 3'd1;
   localparam logic [2:0] EV_NB_VIS   = 3'd2;
   localparam logic [2:0] EV_BACK     = 3'd3;
   localparam logic [2:0] EV_CARVED   = 3'd4;
   localparam logic [2:0] EV_COMPLETE = 3'd5;
   localparam logic [2:0] EV_READ     = 3'd6;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0]        mode;
      logic [1:0]        direction;
      logic [CELL_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [2:0]        event_res;
      logic [CELL_W-1:0] from_cell;
      logic [CELL_W-1:0] to_cell;
      logic [1:0]        carved_direction;
      logic [3:0]        wall_bits;
      logic              cell_visited;
      logic [CNT_W-1:0]  visited_total;
      logic              done_res;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic dec;
      logic eval;
      logic wrcur;
      logic sweep;
      logic rend;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       quick;
      logic       nb_visited;
      logic       sweep_last;
      logic       sweep_restart;
   } ctl_sts_type;

endpackage

`default_nettype wire

// ===== rtl/gmb_ram.sv =====
`default_nettype none

module gmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/gmb_datapath.sv =====
`default_nettype none

module gmb_datapath import gmb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctl_cmd_type          cmd,
   output ctl_sts_type               sts,
   input  wire req_type              req_payload,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata,
   output rsp_type                   rsp_payload
);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw);
      logic [DIM_W-1:0] v;
      v = raw;
      if (v > DIM_MAX) v = DIM_MAX;
      if (v < DIM_MIN) v = DIM_MIN;
      return v;
   endfunction

   // configuration and grid size
   logic [DIM_W-1:0] raw_w_ff, raw_w_in, raw_h_ff, raw_h_in;
   logic [DIM_W-1:0] eff_w_ff, eff_w_in, eff_h_ff, eff_h_in;
   logic [CNT_W-1:0] total_ff, total_in;

   // walker state
   logic [CELL_W-1:0] cur_ff, cur_in;
   logic [CRD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [3:0]        tried_ff, tried_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // clearing sweep
   logic [CELL_W-1:0] cnt_ff, cnt_in;
   logic [CRD_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic              full_ff, full_in;

   // item payload
   logic [1:0]        mode_ff, mode_in, dir_ff, dir_in;
   logic [CELL_W-1:0] idx_ff, idx_in;
   logic [CELL_W-1:0] start_ff, start_in;
   logic [CRD_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic [CELL_W-1:0] nb_ff, nb_in;
   logic [CRD_W-1:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic [2:0]        ev_ff, ev_in;
   logic [CELL_W-1:0] from_ff, from_in;
   logic [1:0]        carved_ff, carved_in;
   logic [3:0]        walls_ff, walls_in;
   logic              vis_ff, vis_in;
   rsp_type           rsp_ff, rsp_in;

   // memories
   logic              grid_we;
   logic [CELL_W-1:0] grid_waddr, grid_raddr;
   logic [GRID_W-1:0] grid_wdata, grid_rdata;
   logic              stk_we;
   logic [CELL_W-1:0] stk_waddr, stk_raddr;
   logic [STK_W-1:0]  stk_wdata, stk_rdata;

   // neighbor decode
   logic [CELL_W-1:0] w_cells, nb, start_sel, sweep_end;
   logic [CRD_W-1:0]  nx, ny;
   logic              blk, complete, is_step;
   logic [3:0]        dir_bit, opp_bit, tried_or;

   gmb_ram #(.WIDTH(GRID_W), .DEPTH(MAX_CELLS)) u_grid_ram (
      .clock (clock),
      .we    (grid_we),
      .waddr (grid_waddr),
      .wdata (grid_wdata),
      .raddr (grid_raddr),
      .rdata (grid_rdata)
   );

   gmb_ram #(.WIDTH(STK_W), .DEPTH(MAX_CELLS)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // neighbor of the current cell in the requested direction
   always_comb begin
      w_cells = CELL_W'(eff_w_ff);
      nb  = cur_ff;
      nx  = cx_ff;
      ny  = cy_ff;
      blk = 1'b0;
      case (dir_ff)
         DIR_UP: begin
            blk = (cy_ff == '0);
            nb  = cur_ff - w_cells;
            ny  = cy_ff - CRD_W'(1);
         end
         DIR_RIGHT: begin
            blk = (({1'b0, cx_ff} + DIM_W'(1)) == eff_w_ff);
            nb  = cur_ff + CELL_W'(1);
            nx  = cx_ff + CRD_W'(1);
         end
         DIR_DOWN: begin
            blk = (({1'b0, cy_ff} + DIM_W'(1)) == eff_h_ff);
            nb  = cur_ff + w_cells;
            ny  = cy_ff + CRD_W'(1);
         end
         default: begin
            blk = (cx_ff == '0);
            nb  = cur_ff - CELL_W'(1);
            nx  = cx_ff - CRD_W'(1);
         end
      endcase
   end

   assign dir_bit   = WALL_ONE << dir_ff;
   assign opp_bit   = WALL_ONE << (dir_ff + 2'd2);
   assign tried_or  = tried_ff | dir_bit;
   assign complete  = (count_ff >= total_ff);
   assign is_step   = (mode_ff == MODE_STEP);
   assign start_sel = ({1'b0, idx_ff} < total_ff) ? idx_ff
                                                  : CELL_W'(total_ff - CNT_W'(1));
   assign sweep_end = full_ff ? CELL_W'(MAX_CELLS - 1) : CELL_W'(total_ff - CNT_W'(1));

   // status to the controller
   assign sts.mode          = mode_ff;
   assign sts.quick         = (count_ff == '0) || complete || blk;
   assign sts.nb_visited    = grid_rdata[GRID_W-1];
   assign sts.sweep_last    = (cnt_ff == sweep_end);
   assign sts.sweep_restart = !full_ff;

   // memory ports
   assign grid_raddr = cmd.dec ? (is_step ? nb : idx_ff) : from_ff;
   assign stk_raddr  = CELL_W'(depth_ff - CNT_W'(2));

   always_comb begin
      grid_we    = 1'b0;
      grid_waddr = cnt_ff;
      grid_wdata = {1'b0, WALLS_ALL};
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[CELL_W-1:0];
      stk_wdata  = {nb_ff, ny_ff, nx_ff};
      if (cmd.sweep) begin
         grid_we    = 1'b1;
         grid_wdata = {(!full_ff && cnt_ff == start_ff), WALLS_ALL};
      end else if (cmd.eval && is_step && !grid_rdata[GRID_W-1]) begin
         grid_we    = 1'b1;
         grid_waddr = nb_ff;
         grid_wdata = {1'b1, grid_rdata[3:0] & ~opp_bit};
         stk_we     = (depth_ff < CNT_W'(MAX_CELLS));
      end else if (cmd.wrcur) begin
         grid_we    = 1'b1;
         grid_waddr = from_ff;
         grid_wdata = {1'b1, grid_rdata[3:0] & ~dir_bit};
      end
      if (cmd.rend) begin
         stk_we    = 1'b1;
         stk_waddr = '0;
         stk_wdata = {start_ff, sy_ff, sx_ff};
      end
   end

   // next state
   always_comb begin
      raw_w_in  = raw_w_ff;
      raw_h_in  = raw_h_ff;
      eff_w_in  = clamp_dim(raw_w_ff);
      eff_h_in  = clamp_dim(raw_h_ff);
      total_in  = CNT_W'(eff_w_ff) * CNT_W'(eff_h_ff);
      cur_in    = cur_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      depth_in  = depth_ff;
      tried_in  = tried_ff;
      count_in  = count_ff;
      cnt_in    = cnt_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      full_in   = full_ff;
      mode_in   = mode_ff;
      dir_in    = dir_ff;
      idx_in    = idx_ff;
      start_in  = start_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      nb_in     = nb_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      ev_in     = ev_ff;
      from_in   = from_ff;
      carved_in = carved_ff;
      walls_in  = walls_ff;
      vis_in    = vis_ff;
      rsp_in    = rsp_ff;

      // input transfer
      if (cmd.accept) begin
         mode_in = req_payload.mode;
         dir_in  = req_payload.direction;
         idx_in  = req_payload.cell_index;
      end

      // clearing sweep with row and column tracking for the start cell
      if (cmd.sweep) begin
         cnt_in = cnt_ff + CELL_W'(1);
         if (({1'b0, col_ff} + DIM_W'(1)) == eff_w_ff) begin
            col_in = '0;
            row_in = row_ff + CRD_W'(1);
         end else begin
            col_in = col_ff + CRD_W'(1);
         end
         if (!full_ff && cnt_ff == start_ff) begin
            sx_in = col_ff;
            sy_in = row_ff;
         end
      end

      // decode: quick answers, restart setup, neighbor capture
      if (cmd.dec) begin
         from_in   = cur_ff;
         carved_in = DIR_UP;
         walls_in  = WALLS_NONE;
         vis_in    = 1'b0;
         nb_in     = nb;
         nx_in     = nx;
         ny_in     = ny;
         case (mode_ff)
            MODE_RESTART: begin
               ev_in    = EV_STARTED;
               start_in = start_sel;
               cnt_in   = '0;
               col_in   = '0;
               row_in   = '0;
               full_in  = 1'b0;
            end
            MODE_STEP: begin
               if (count_ff == '0) begin
                  ev_in = EV_BLOCKED;
               end else if (complete) begin
                  ev_in = EV_COMPLETE;
               end else if (blk) begin
                  ev_in    = EV_BLOCKED;
                  tried_in = tried_or;
               end
            end
            default: begin
               ev_in   = EV_READ;
               from_in = idx_ff;
            end
         endcase
      end

      // evaluate the neighbor or the read cell
      if (cmd.eval) begin
         if (!is_step) begin
            if ({1'b0, idx_ff} < total_ff) begin
               walls_in = grid_rdata[3:0];
               vis_in   = grid_rdata[GRID_W-1];
            end else begin
               walls_in = WALLS_ALL;
               vis_in   = 1'b0;
            end
         end else if (grid_rdata[GRID_W-1]) begin
            if (tried_or == WALLS_ALL) begin
               tried_in = '0;
               ev_in    = EV_BACK;
               if (depth_ff > CNT_W'(1)) begin
                  depth_in = depth_ff - CNT_W'(1);
                  cur_in   = stk_rdata[STK_W-1 -: CELL_W];
                  cy_in    = stk_rdata[2*CRD_W-1 -: CRD_W];
                  cx_in    = stk_rdata[CRD_W-1:0];
               end
            end else begin
               tried_in = tried_or;
               ev_in    = EV_NB_VIS;
            end
         end else begin
            if (depth_ff < CNT_W'(MAX_CELLS)) begin
               depth_in = depth_ff + CNT_W'(1);
            end
            cur_in    = nb_ff;
            cx_in     = nx_ff;
            cy_in     = ny_ff;
            tried_in  = '0;
            count_in  = count_ff + CNT_W'(1);
            carved_in = dir_ff;
            ev_in     = EV_CARVED;
         end
      end

      // end of restart: start cell becomes the stack bottom
      if (cmd.rend) begin
         cur_in   = start_ff;
         cx_in    = sx_ff;
         cy_in    = sy_ff;
         depth_in = CNT_W'(1);
         tried_in = '0;
         count_in = CNT_W'(1);
      end

      // result register load
      if (cmd.load_rsp) begin
         rsp_in.event_res        = ev_ff;
         rsp_in.from_cell        = from_ff;
         rsp_in.to_cell          = cur_ff;
         rsp_in.carved_direction = carved_ff;
         rsp_in.wall_bits        = walls_ff;
         rsp_in.cell_visited     = vis_ff;
         rsp_in.visited_total    = count_ff;
         rsp_in.done_res         = (count_ff != '0) && complete;
      end

      // register write clears the maze and starts a full sweep
      if (csr_we) begin
         case (csr_index)
            REG_WIDTH:  raw_w_in = csr_wdata;
            REG_HEIGHT: raw_h_in = csr_wdata;
            default:    raw_w_in = raw_w_ff;
         endcase
         cur_in   = '0;
         cx_in    = '0;
         cy_in    = '0;
         depth_in = '0;
         tried_in = '0;
         count_in = '0;
         cnt_in   = '0;
         col_in   = '0;
         row_in   = '0;
         full_in  = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_w_ff <= DIM_RESET;
         raw_h_ff <= DIM_RESET;
         eff_w_ff <= DIM_RESET;
         eff_h_ff <= DIM_RESET;
         total_ff <= TOTAL_RESET;
         cur_ff   <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         depth_ff <= '0;
         tried_ff <= '0;
         count_ff <= '0;
         cnt_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         full_ff  <= 1'b1;
      end else begin
         raw_w_ff <= raw_w_in;
         raw_h_ff <= raw_h_in;
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
         total_ff <= total_in;
         cur_ff   <= cur_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         depth_ff <= depth_in;
         tried_ff <= tried_in;
         count_ff <= count_in;
         cnt_ff   <= cnt_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         full_ff  <= full_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      dir_ff    <= dir_in;
      idx_ff    <= idx_in;
      start_ff  <= start_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      nb_ff     <= nb_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      ev_ff     <= ev_in;
      from_ff   <= from_in;
      carved_ff <= carved_in;
      walls_ff  <= walls_in;
      vis_ff    <= vis_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/gmb_ctl.sv =====
`default_nettype none

module gmb_ctl import gmb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        csr_we,
   input  wire ctl_sts_type sts,
   output ctl_cmd_type      cmd
);

   localparam logic [2:0] S_SWEEP = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DEC   = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_WRCUR = 3'd4;
   localparam logic [2:0] S_REND  = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // state sequencing
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = sts.sweep_restart ? S_REND : S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DEC;
            end
         end
         S_DEC: begin
            cmd.dec = 1'b1;
            case (sts.mode)
               MODE_RESTART: state_in = S_SWEEP;
               MODE_STEP:    state_in = sts.quick ? S_FIN : S_EVAL;
               default:      state_in = S_EVAL;
            endcase
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.mode == MODE_STEP && !sts.nb_visited) begin
               state_in = S_WRCUR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_WRCUR: begin
            cmd.wrcur = 1'b1;
            state_in  = S_FIN;
         end
         S_REND: begin
            cmd.rend = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.accept = 1'b1;
                  state_in   = S_DEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_we) begin
         state_in = S_SWEEP;
      end
   end

   // output register valid
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/grid_maze_backtracker_top.sv =====
// edge-blocked and already-complete steps go from decode to the result register;
//   reads, neighbor-visited and backtrack steps add EVAL, carving also WRCUR (grid port)
// restart: grid_width * grid_height cells cleared, one grid memory cell per cycle, then REND
// throughput: one item at a time; the next item is taken as the result is loaded
// reset and any register write: clear of all 4096 grid memory cells, no item taken meanwhile
// reset is synchronous, active high
`default_nettype none

module grid_maze_backtracker_top import gmb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencer
   gmb_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .sts       (sts),
      .cmd       (cmd)
   );

   // maze state, memories and result register
   gmb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
